FILE: hw/rtl/mf3_pkg.sv
// Shared types, constants and the 9-input median network for the 3x3 median filter.
// Used by median_filter_3x3_top and its testbench through scoped names.
package mf3_pkg;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 11;
  localparam int CFG_W   = 12;

  // Default size limits and register reset values
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int MIN_SIZE       = 3;

  localparam int WIN_CELLS = 9;
  localparam int WIN_MID   = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Bit positions of the pending-result mask, in emission order
  localparam int RES_CENTER   = 0;  // delayed pixel (x-1,y-1)
  localparam int RES_EDGE     = 1;  // right border pixel of the row above
  localparam int RES_LAST_ROW = 2;  // current pixel on the last row
  localparam int RES_KINDS    = 3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t win_t [WIN_CELLS];

  // Compare-exchange: returns {min, max}
  function automatic logic [2*PIX_W-1:0] cmp_swap(input pix_t a, input pix_t b);
    if (a > b) begin
      cmp_swap = {b, a};
    end else begin
      cmp_swap = {a, b};
    end
  endfunction

  // 19-exchange median-of-nine network
  function automatic pix_t median9(input win_t w);
    pix_t s [WIN_CELLS];
    s = w;
    {s[1], s[2]} = cmp_swap(s[1], s[2]);
    {s[4], s[5]} = cmp_swap(s[4], s[5]);
    {s[7], s[8]} = cmp_swap(s[7], s[8]);
    {s[0], s[1]} = cmp_swap(s[0], s[1]);
    {s[3], s[4]} = cmp_swap(s[3], s[4]);
    {s[6], s[7]} = cmp_swap(s[6], s[7]);
    {s[1], s[2]} = cmp_swap(s[1], s[2]);
    {s[4], s[5]} = cmp_swap(s[4], s[5]);
    {s[7], s[8]} = cmp_swap(s[7], s[8]);
    {s[0], s[3]} = cmp_swap(s[0], s[3]);
    {s[5], s[8]} = cmp_swap(s[5], s[8]);
    {s[4], s[7]} = cmp_swap(s[4], s[7]);
    {s[3], s[6]} = cmp_swap(s[3], s[6]);
    {s[1], s[4]} = cmp_swap(s[1], s[4]);
    {s[2], s[5]} = cmp_swap(s[2], s[5]);
    {s[4], s[7]} = cmp_swap(s[4], s[7]);
    {s[4], s[2]} = cmp_swap(s[4], s[2]);
    {s[6], s[4]} = cmp_swap(s[6], s[4]);
    {s[4], s[2]} = cmp_swap(s[4], s[2]);
    median9 = s[WIN_MID];
  endfunction

endpackage

FILE: hw/rtl/mf3_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module mf3_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2048,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/median_filter_3x3_top.sv
// 3x3 median filter over a raster stream of 8-bit gray pixels.
// Depends on mf3_pkg and mf3_ram (two line stores).
//
// Usage:
//   Input channel in_valid/in_ready/in_pixel_in takes pixels in raster order.
//   Output channel out_valid/out_ready carries pixel, column, row and a flag
//   marking the last result caused by one input pixel. Pixel (x-1,y-1) comes
//   out when pixel (x,y) arrives: the median of its 3x3 neighborhood inside
//   the frame, the original value on the border. The last pixel of a row also
//   releases the right border pixel of the row above; every pixel of the
//   last row is passed straight out as well.
//   Frame size is set through cfg_we/cfg_index/cfg_data and is clamped to
//   [3, MAX_WIDTH] x [3, MAX_HEIGHT]; write it only while the block is idle.
// Timing:
//   A result passes the input register (its transfer also reads the line
//   stores), then the window register, then the output register. At row ends
//   and on the last row the window stage holds until every extra result of
//   the pixel has been emitted, and a new pixel waits in the input register.
// Reset: clears counters, window and pipeline valids; line stores are not
//   cleared. A stalled receiver holds the output register and, once the
//   window stage and the input register are full, drops in_ready.
module median_filter_3x3_top #(
  parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]        cfg_data,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mf3_pkg::PIX_W-1:0]        in_pixel_in,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mf3_pkg::PIX_W-1:0]        out_pixel_out,
  output logic [mf3_pkg::COORD_W-1:0]      out_column,
  output logic [mf3_pkg::COORD_W-1:0]      out_row,
  output logic                             out_last_of_run
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;   // column index
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1; // row index
  localparam int WW = $clog2(MAX_WIDTH + 1);                     // width value
  localparam int HW = $clog2(MAX_HEIGHT + 1);                    // height value
  localparam int W_RESET = (mf3_pkg::RESET_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : mf3_pkg::RESET_WIDTH;
  localparam int H_RESET = (mf3_pkg::RESET_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : mf3_pkg::RESET_HEIGHT;
  localparam int NK = mf3_pkg::RES_KINDS;

  // ---------------------------------------------------------------------
  // Configuration: sizes stored already clamped
  logic [WW-1:0] w_r, w_nxt, cfg_w_clamped;
  logic [HW-1:0] h_r, h_nxt, cfg_h_clamped;

  always_comb begin
    if (cfg_data < mf3_pkg::CFG_W'(mf3_pkg::MIN_SIZE)) begin
      cfg_w_clamped = WW'(mf3_pkg::MIN_SIZE);
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      cfg_w_clamped = WW'(MAX_WIDTH);
    end else begin
      cfg_w_clamped = WW'(cfg_data);
    end
    if (cfg_data < mf3_pkg::CFG_W'(mf3_pkg::MIN_SIZE)) begin
      cfg_h_clamped = HW'(mf3_pkg::MIN_SIZE);
    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      cfg_h_clamped = HW'(MAX_HEIGHT);
    end else begin
      cfg_h_clamped = HW'(cfg_data);
    end
  end

  // register decode
  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mf3_pkg::REG_IMAGE_WIDTH:  w_nxt = cfg_w_clamped;
        mf3_pkg::REG_IMAGE_HEIGHT: h_nxt = cfg_h_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WW'(W_RESET);
      h_r <= HW'(H_RESET);
    end else begin
      w_r <= w_nxt;
      h_r <= h_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake control
  logic          in_xfer, s1_adv, s2_free, emit, slot_free;
  logic          s1_valid_r, s2_valid_r, out_valid_r;
  logic [NK-1:0] pend_r, pend_after;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = s2_valid_r && (pend_r != '0) && slot_free;
  assign s2_free   = !s2_valid_r || (pend_r == '0) || (emit && (pend_after == '0));
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_ready  = !s1_valid_r || s2_free;
  assign in_xfer   = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Position counters: normalize to (x,y), then step to the next position
  logic [CW-1:0] col_r, col_nxt, x_cur;
  logic [RW-1:0] row_r, row_nxt, y_cur;
  logic          col_wrap;
  logic [HW-1:0] row_inc, y_inc;
  logic [WW-1:0] x_inc;

  always_comb begin
    col_wrap = WW'(col_r) >= w_r;
    row_inc  = HW'(row_r) + HW'(col_wrap);
    x_cur    = col_wrap ? '0 : col_r;
    y_cur    = (row_inc >= h_r) ? '0 : RW'(row_inc);
    x_inc    = WW'(x_cur) + WW'(1);
    y_inc    = HW'(y_cur) + HW'(1);
    if (x_inc >= w_r) begin
      col_nxt = '0;
      row_nxt = (y_inc >= h_r) ? '0 : RW'(y_inc);
    end else begin
      col_nxt = CW'(x_inc);
      row_nxt = y_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_xfer) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register; line stores are read at x in the same transfer
  logic [NK-1:0]        pend_in;
  logic                 inner_in;
  mf3_pkg::pix_t        s1_pix_r;
  logic [CW-1:0]        s1_x_r;
  logic [RW-1:0]        s1_y_r;
  logic [NK-1:0]        s1_pend_r;
  logic                 s1_inner_r;
  mf3_pkg::pix_t        top_rd, mid_rd;

  always_comb begin
    pend_in = '0;
    pend_in[mf3_pkg::RES_CENTER]   = (y_cur != '0) && (x_cur != '0);
    pend_in[mf3_pkg::RES_EDGE]     = (y_cur != '0) && (WW'(x_cur) == w_r - WW'(1));
    pend_in[mf3_pkg::RES_LAST_ROW] = (HW'(y_cur) == h_r - HW'(1));
    // x < w and y < h always, so only the low border needs a check
    inner_in = (x_cur >= CW'(2)) && (y_cur >= RW'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_r   <= in_pixel_in;
      s1_x_r     <= x_cur;
      s1_y_r     <= y_cur;
      s1_pend_r  <= pend_in;
      s1_inner_r <= inner_in;
    end
  end

  // Older store gets the newer row's value, newer store gets the new pixel
  mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_older (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_x_r),
    .wr_data (mid_rd),
    .rd_en   (in_xfer),
    .rd_addr (x_cur),
    .rd_data (top_rd)
  );

  mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_newer (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_x_r),
    .wr_data (s1_pix_r),
    .rd_en   (in_xfer),
    .rd_addr (x_cur),
    .rd_data (mid_rd)
  );

  // ---------------------------------------------------------------------
  // Stage 2: 3x3 window plus the pending results of one pixel
  mf3_pkg::win_t win_r, win_nxt;
  mf3_pkg::pix_t s2_pix_r, s2_mid_r;
  logic [CW-1:0] s2_x_r;
  logic [RW-1:0] s2_y_r;
  logic          s2_inner_r;

  // window shifts one column left, new right column from stores and input
  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top_rd;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_rd;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      pend_r     <= '0;
      for (int i = 0; i < mf3_pkg::WIN_CELLS; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      s2_valid_r <= 1'b1;
      pend_r     <= s1_pend_r;
      win_r      <= win_nxt;
    end else if (s2_free) begin
      s2_valid_r <= 1'b0;
      pend_r     <= '0;
    end else if (emit) begin
      pend_r     <= pend_after;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_pix_r   <= s1_pix_r;
      s2_mid_r   <= mid_rd;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s2_inner_r <= s1_inner_r;
    end
  end

  // Pick the earliest pending result
  mf3_pkg::pix_t               res_pix;
  logic [mf3_pkg::COORD_W-1:0] res_col, res_row;

  always_comb begin
    pend_after = pend_r;
    if (pend_r[mf3_pkg::RES_CENTER]) begin
      pend_after[mf3_pkg::RES_CENTER] = 1'b0;
      res_pix = s2_inner_r ? mf3_pkg::median9(win_r) : win_r[mf3_pkg::WIN_MID];
      res_col = mf3_pkg::COORD_W'(s2_x_r - CW'(1));
      res_row = mf3_pkg::COORD_W'(s2_y_r - RW'(1));
    end else if (pend_r[mf3_pkg::RES_EDGE]) begin
      pend_after[mf3_pkg::RES_EDGE] = 1'b0;
      res_pix = s2_mid_r;
      res_col = mf3_pkg::COORD_W'(s2_x_r);
      res_row = mf3_pkg::COORD_W'(s2_y_r - RW'(1));
    end else begin
      pend_after[mf3_pkg::RES_LAST_ROW] = 1'b0;
      res_pix = s2_pix_r;
      res_col = mf3_pkg::COORD_W'(s2_x_r);
      res_row = mf3_pkg::COORD_W'(s2_y_r);
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  mf3_pkg::pix_t               out_pix_r;
  logic [mf3_pkg::COORD_W-1:0] out_col_r, out_row_r;
  logic                        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix_r  <= res_pix;
      out_col_r  <= res_col;
      out_row_r  <= res_row;
      out_last_r <= (pend_after == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_column      = out_col_r;
  assign out_row         = out_row_r;
  assign out_last_of_run = out_last_r;

`ifndef ASSERT_OFF
  // pending results only exist in an occupied window stage
  a_pend_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> s2_valid_r)
    else $error("pending results in empty window stage");

  // line store write and a new read never hit the same column together
  a_no_store_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && s1_adv) |-> (x_cur != s1_x_r))
    else $error("line store read/write clash");

  // a result that is not the last of its pixel is always followed by another
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |=> out_valid_r)
    else $error("result run cut short");

  // input stalls only when the input register and the window stage are occupied
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s2_valid_r))
    else $error("input stalled without a full pipeline");
`endif

endmodule

FILE: verif/median_filter_3x3_top_tb.sv
// Self-checking testbench for median_filter_3x3_top: directed plan, then random frames.
// Depends on mf3_pkg for field widths, register indexes and size limits.
// Expected pixels come from a cycle-free model of line stores, 3x3 window and counters.
module median_filter_3x3_top_tb;

  typedef struct packed {
    mf3_pkg::pix_t               pix;
    logic [mf3_pkg::COORD_W-1:0] col;
    logic [mf3_pkg::COORD_W-1:0] row;
    logic                        last;
  } filt_pixel_t;

  typedef enum {OP_PIXEL, OP_WRITE, OP_FILL, OP_FINISH_FRAME} stim_op_t;

  // one row of the directed plan; n_typed < 0 means the model decides
  typedef struct {
    stim_op_t                      op;
    logic [mf3_pkg::CFG_IDX_W-1:0] reg_sel;
    int                            value;
    int                            n_typed;
    int                            t_pix;
    int                            t_col;
    int                            t_row;
  } plan_row_t;

  localparam int NPLAN = 21;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index = mf3_pkg::REG_IMAGE_WIDTH;
  logic [mf3_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  mf3_pkg::pix_t                 in_pixel_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  mf3_pkg::pix_t                 out_pixel_out;
  logic [mf3_pkg::COORD_W-1:0]   out_column;
  logic [mf3_pkg::COORD_W-1:0]   out_row;
  logic                          out_last_of_run;

  median_filter_3x3_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Filter model state
  logic [mf3_pkg::CFG_W-1:0] width_reg  = mf3_pkg::CFG_W'(mf3_pkg::RESET_WIDTH);
  logic [mf3_pkg::CFG_W-1:0] height_reg = mf3_pkg::CFG_W'(mf3_pkg::RESET_HEIGHT);
  mf3_pkg::pix_t    line_prev2 [mf3_pkg::MAX_WIDTH_DEF];
  mf3_pkg::pix_t    line_prev1 [mf3_pkg::MAX_WIDTH_DEF];
  mf3_pkg::pix_t    nbhd [9];
  int               col_pos = 0;
  int               row_pos = 0;
  filt_pixel_t      step_out [3];

  filt_pixel_t      expected_pixels [$];
  int               fail_count = 0;
  int               pix_mode = 0;
  bit               src_calm = 1'b0;
  bit               sink_calm = 1'b0;
  int               stall_left = 0;

  function automatic int clamped(input int v, input int hi);
    if (v < mf3_pkg::MIN_SIZE) return mf3_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // rank-based median: the cell with at most 4 smaller and at least 5 not larger
  function automatic mf3_pkg::pix_t nbhd_median();
    int lt, le, i, j;
    for (i = 0; i < 9; i++) begin
      lt = 0;
      le = 0;
      for (j = 0; j < 9; j++) begin
        if (nbhd[j] < nbhd[i]) lt++;
        if (nbhd[j] <= nbhd[i]) le++;
      end
      if (lt <= 4 && le >= 5) return nbhd[i];
    end
    return nbhd[4];
  endfunction

  // advance the model by one pixel; results land in step_out, count returned
  function automatic int filter_step(input mf3_pkg::pix_t p);
    int            w, h, x, y, n, r;
    mf3_pkg::pix_t top, mid, v;
    w = clamped(width_reg, mf3_pkg::MAX_WIDTH_DEF);
    h = clamped(height_reg, mf3_pkg::MAX_HEIGHT_DEF);
    n = 0;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;
    top = line_prev2[x];
    mid = line_prev1[x];
    for (r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = top;
    nbhd[5] = mid;
    nbhd[8] = p;
    line_prev2[x] = mid;
    line_prev1[x] = p;
    // delayed center pixel
    if (y >= 1 && x >= 1) begin
      if (x - 1 >= 1 && x - 1 <= w - 2 && y - 1 >= 1 && y - 1 <= h - 2) begin
        v = nbhd_median();
      end else begin
        v = nbhd[4];
      end
      step_out[n] = '{v, mf3_pkg::COORD_W'(x - 1), mf3_pkg::COORD_W'(y - 1), 1'b0};
      n++;
    end
    // right border of the row above
    if (y >= 1 && x == w - 1) begin
      step_out[n] = '{mid, mf3_pkg::COORD_W'(w - 1), mf3_pkg::COORD_W'(y - 1), 1'b0};
      n++;
    end
    // last row passes straight through
    if (y == h - 1) begin
      step_out[n] = '{p, mf3_pkg::COORD_W'(x), mf3_pkg::COORD_W'(y), 1'b0};
      n++;
    end
    if (n > 0) step_out[n-1].last = 1'b1;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return n;
  endfunction

  function automatic bit at_frame_start();
    int c, r;
    c = col_pos;
    r = row_pos;
    if (c >= clamped(width_reg, mf3_pkg::MAX_WIDTH_DEF)) begin
      c = 0;
      r++;
    end
    if (r >= clamped(height_reg, mf3_pkg::MAX_HEIGHT_DEF)) r = 0;
    return (c == 0 && r == 0);
  endfunction

  function automatic mf3_pkg::pix_t rand_pixel();
    case (pix_mode)
      0:       return mf3_pkg::pix_t'($urandom_range(0, 255));
      1:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return mf3_pkg::pix_t'($urandom_range(100, 103));  // many ties
    endcase
  endfunction

  function automatic int source_gap();
    int r;
    if (src_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(3, 6);
    if (r < 88) return $urandom_range(7, 10);
    return $urandom_range(0, 2);  // saturates to the minimum
  endfunction

  // Input channel: one transfer per call, model stepped at the accepting edge
  task automatic send_pixel(input mf3_pkg::pix_t p, input int n_typed,
                            input filt_pixel_t typed);
    int gap, n, k;
    gap = source_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = filter_step(p);
    if (n_typed < 0) begin
      for (k = 0; k < n; k++) expected_pixels.push_back(step_out[k]);
    end else if (n_typed == 1) begin
      expected_pixels.push_back(typed);
    end
  endtask

  task automatic send_random();
    send_pixel(rand_pixel(), -1, '0);
  endtask

  // wait until every result is out and the pipeline has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mf3_pkg::CFG_IDX_W-1:0] sel, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= mf3_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == mf3_pkg::REG_IMAGE_WIDTH) begin
      width_reg = mf3_pkg::CFG_W'(val);
    end else begin
      height_reg = mf3_pkg::CFG_W'(val);
    end
    @(posedge clk);
  endtask

  // Result channel: random back-pressure, mostly short
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!sink_calm && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2) : $urandom_range(8, 24);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    filt_pixel_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_out %0d column %0d row %0d",
               out_pixel_out, out_column, out_row);
        fail_count++;
      end else begin
        e = expected_pixels.pop_front();
        if (out_pixel_out !== e.pix) begin
          $error("pixel_out: expected %0d, got %0d", e.pix, out_pixel_out);
          fail_count++;
        end
        if (out_column !== e.col) begin
          $error("out_column: expected %0d, got %0d", e.col, out_column);
          fail_count++;
        end
        if (out_row !== e.row) begin
          $error("out_row: expected %0d, got %0d", e.row, out_row);
          fail_count++;
        end
        if (out_last_of_run !== e.last) begin
          $error("last_of_run: expected %0d, got %0d", e.last, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Sequencer
  initial begin
    plan_row_t   plan [NPLAN];
    filt_pixel_t typed;
    int          i, w, h, frames, total, rand_items, sel;

    foreach (line_prev1[k]) begin
      line_prev1[k] = '0;
      line_prev2[k] = '0;
    end
    foreach (nbhd[k]) nbhd[k] = '0;

    plan = '{
      // reset size, first row: nothing comes out
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  0,    0, 0,   0, 0},
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  255,  0, 0,   0, 0},
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  85,   0, 0,   0, 0},
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  170,  0, 0,   0, 0},
      '{OP_FILL,         mf3_pkg::REG_IMAGE_WIDTH,  8,   -1, 0,   0, 0},
      // shrink to 3x3 mid-row; below-minimum values saturate
      '{OP_WRITE,        mf3_pkg::REG_IMAGE_WIDTH,  0,   -1, 0,   0, 0},
      '{OP_WRITE,        mf3_pkg::REG_IMAGE_HEIGHT, 1,   -1, 0,   0, 0},
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  0,    0, 0,   0, 0},
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  255, -1, 0,   0, 0},
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  0,   -1, 0,   0, 0},
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  255,  1, 255, 0, 2},
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  255, -1, 0,   0, 0},
      '{OP_PIXEL,        mf3_pkg::REG_IMAGE_WIDTH,  0,   -1, 0,   0, 0},
      // widest row, then cut back to 3 columns within the frame
      '{OP_WRITE,        mf3_pkg::REG_IMAGE_WIDTH,  4095, -1, 0,  0, 0},
      '{OP_FILL,         mf3_pkg::REG_IMAGE_WIDTH,  6,   -1, 0,   0, 0},
      '{OP_WRITE,        mf3_pkg::REG_IMAGE_WIDTH,  3,   -1, 0,   0, 0},
      '{OP_FINISH_FRAME, mf3_pkg::REG_IMAGE_WIDTH,  0,   -1, 0,   0, 0},
      // tallest frame, then row counter restarts under a smaller height
      '{OP_WRITE,        mf3_pkg::REG_IMAGE_HEIGHT, 4095, -1, 0,  0, 0},
      '{OP_FILL,         mf3_pkg::REG_IMAGE_WIDTH,  12,  -1, 0,   0, 0},
      '{OP_WRITE,        mf3_pkg::REG_IMAGE_HEIGHT, 2,   -1, 0,   0, 0},
      '{OP_FILL,         mf3_pkg::REG_IMAGE_WIDTH,  9,   -1, 0,   0, 0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan
    for (i = 0; i < NPLAN; i++) begin
      case (plan[i].op)
        OP_PIXEL: begin
          typed = '{mf3_pkg::pix_t'(plan[i].t_pix), mf3_pkg::COORD_W'(plan[i].t_col),
                    mf3_pkg::COORD_W'(plan[i].t_row), 1'b1};
          send_pixel(mf3_pkg::pix_t'(plan[i].value), plan[i].n_typed, typed);
        end
        OP_WRITE: begin
          wait_idle();
          write_reg(plan[i].reg_sel, plan[i].value);
        end
        OP_FILL: begin
          repeat (plan[i].value) send_random();
        end
        default: begin
          while (!at_frame_start()) send_random();
        end
      endcase
    end

    // Random frames, size changed only at frame boundaries
    rand_items = 0;
    while (rand_items < 110) begin
      wait_idle();
      w   = pick_size();
      h   = pick_size();
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
        write_reg(mf3_pkg::REG_IMAGE_WIDTH, w);
      end else if (sel == 1) begin
        write_reg(mf3_pkg::REG_IMAGE_HEIGHT, h);
      end else if (sel == 2) begin
        write_reg(mf3_pkg::REG_IMAGE_WIDTH, w);
        write_reg(mf3_pkg::REG_IMAGE_HEIGHT, h);
      end else begin
        write_reg(mf3_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(mf3_pkg::REG_IMAGE_WIDTH, w);
      end
      src_calm  = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      pix_mode  = $urandom_range(0, 2);
      frames    = $urandom_range(1, 2);
      total     = frames * clamped(width_reg, mf3_pkg::MAX_WIDTH_DEF)
                         * clamped(height_reg, mf3_pkg::MAX_HEIGHT_DEF);
      repeat (total) begin
        send_random();
        rand_items++;
      end
    end

    // Drain
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
